/* hw/rtl/fms_pkg.sv */
`timescale 1ns / 1ps

package fms_pkg;

  // action codes
  localparam logic [1:0] ACT_PUSH = 2'd0;
  localparam logic [1:0] ACT_POP  = 2'd1;
  localparam logic [1:0] ACT_PEEK = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [1:0] ST_BADSTACK  = 2'd3;

  localparam int CAP_W     = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
  localparam int DATA_W    = 32;

  typedef struct packed {
    logic [1:0]               action;
    logic [1:0]               stack_sel;
    logic signed [DATA_W-1:0] push_value;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic [1:0]               status;
    logic                     empty_flag;
    logic                     full_flag;
  } rsp_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } state_t;

  // controller commands to the datapath
  typedef struct packed {
    logic latch;  // capture the request
    logic exec;   // check, update count, access the store
    logic load;   // register the result
  } cmd_t;

endpackage

/* hw/rtl/fms_ram.sv */
`timescale 1ns / 1ps

module fms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 48,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/fms_ctrl.sv */
`timescale 1ns / 1ps

module fms_ctrl
  import fms_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  output cmd_t cmd
);

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    unique case (state)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.latch  = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = S_RESP;
      end
      S_RESP: begin
        cmd.load   = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/fms_datapath.sv */
`timescale 1ns / 1ps

module fms_datapath
  import fms_pkg::*;
#(
  parameter int NUM_STACKS = 3,
  parameter int MAX_DEPTH  = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  cmd_t             cmd,
  input  req_t             req,
  input  logic             cfg_valid,
  input  logic [CAP_W-1:0] cfg_data,
  output rsp_t             rsp,
  output logic             done
);

  localparam int DEPTH  = NUM_STACKS * MAX_DEPTH;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(MAX_DEPTH + 1);
  localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int SEL_W  = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam int SX_W   = (SEL_W > 2) ? SEL_W : 2;

  // captured request
  logic [1:0]        act_q;
  logic [1:0]        sel_q;
  logic [DATA_W-1:0] val_q;

  logic [CAP_W-1:0]  capacity;
  logic [CNT_W-1:0]  counts [NUM_STACKS];

  // result stage between exec and load
  logic              rd_ok_q;
  logic [1:0]        status_q;
  logic              empty_q;
  logic              full_q;

  logic [SX_W-1:0]   sel_x;
  logic [SEL_W-1:0]  idx;
  logic              bad;
  logic [CNT_W-1:0]  cap;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  cnt_next;
  logic              push_ok;
  logic              rd_ok;
  logic [1:0]        status;
  logic [AW-1:0]     base;
  logic [AW-1:0]     addr;
  logic [DATA_W-1:0] rdata;

  // capture request
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      act_q <= req.action;
      sel_q <= req.stack_sel;
      val_q <= req.push_value;
    end
  end

  // capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_valid) begin
      capacity <= cfg_data;
    end
  end

  // capacity clipped to the built depth
  always_comb begin
    if (CMP_W'(capacity) > CMP_W'(MAX_DEPTH)) begin
      cap = CNT_W'(MAX_DEPTH);
    end else begin
      cap = CNT_W'(capacity);
    end
  end

  // stack selection and operation check
  assign sel_x = SX_W'(sel_q);
  assign idx   = sel_x[SEL_W-1:0];
  assign bad   = {3'b000, sel_q} >= 5'(NUM_STACKS);
  assign cnt   = bad ? '0 : counts[idx];

  always_comb begin
    push_ok  = 1'b0;
    rd_ok    = 1'b0;
    status   = ST_OK;
    cnt_next = cnt;
    case (act_q) inside
      ACT_PUSH: begin
        if (cnt >= cap) begin
          status = ST_OVERFLOW;
        end else begin
          push_ok  = 1'b1;
          cnt_next = cnt + 1'b1;
        end
      end
      ACT_POP, ACT_PEEK: begin
        if (cnt == '0) begin
          status = ST_UNDERFLOW;
        end else begin
          rd_ok = 1'b1;
          if (act_q == ACT_POP) begin
            cnt_next = cnt - 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    if (bad) begin
      push_ok = 1'b0;
      rd_ok   = 1'b0;
      status  = ST_BADSTACK;
    end
  end

  // slot address: slice base plus top of stack
  assign base = AW'(idx) * AW'(MAX_DEPTH);
  assign addr = push_ok ? base + AW'(cnt) : base + AW'(cnt - 1'b1);

  // fill counts
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_STACKS; i++) begin
        counts[i] <= '0;
      end
    end else if (cmd.exec && !bad) begin
      counts[idx] <= cnt_next;
    end
  end

  fms_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.exec && push_ok),
    .waddr (addr),
    .wdata (val_q),
    .re    (cmd.exec && rd_ok),
    .raddr (addr),
    .rdata (rdata)
  );

  // status and flags after the operation
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rd_ok_q  <= rd_ok;
      status_q <= status;
      empty_q  <= !bad && (cnt_next == '0);
      full_q   <= !bad && (cnt_next >= cap);
    end
  end

  // result register and strobe
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rsp.data       <= rd_ok_q ? rdata : '0;
      rsp.status     <= status_q;
      rsp.empty_flag <= empty_q;
      rsp.full_flag  <= full_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.load;
    end
  end

endmodule

/* hw/rtl/fixed_multi_stack.sv */
`timescale 1ns / 1ps

// Several fixed-size stacks of 32-bit signed values sharing one memory.
// Each stack owns a slice of MAX_DEPTH entries; capacity limits how many
// entries per stack are in use.
//
// Request channel: drive req and raise start; the request is taken at a
// rising edge with start high and busy low. busy stays high while the
// request is worked on.
// Result channel: done pulses for one cycle with rsp valid in that cycle.
// The receiver cannot stall; the result must be taken when done is high.
// Config channel: cfg_ready is always high; a write with cfg_valid sets
// capacity. Write it only while no request is in flight.
//
// Requests do not overlap: the controller runs the sequence capture,
// store access (registered read of the shared memory), result load,
// and takes no new request before that sequence ends. A new request is
// taken in the cycle the result strobes.
// Reset: all stacks empty, capacity 16; the memory is not cleared.
module fixed_multi_stack
  import fms_pkg::*;
#(
  parameter int NUM_STACKS = 3,
  parameter int MAX_DEPTH  = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  req_t             req,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CAP_W-1:0] cfg_data,
  output rsp_t             rsp,
  output logic             done
);

  cmd_t cmd;

  assign cfg_ready = 1'b1;

  fms_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  fms_datapath #(
    .NUM_STACKS (NUM_STACKS),
    .MAX_DEPTH  (MAX_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .req       (req),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .rsp       (rsp),
    .done      (done)
  );

endmodule
